[rtl/prp_pkg.sv]
// types, constants and helper functions for the capture record byte parser
// used by every module of the block; no dependencies of its own
`default_nettype none

package prp_pkg;

    localparam int TIME_BYTES   = 8;
    localparam int LENGTH_BYTES = 4;
    localparam int SKIP_BYTES   = 16;
    localparam int Q_DEPTH      = 2;

    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_STRIP   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_PAY = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        PH_TIME    = 2'd0,
        PH_CAPLEN  = 2'd1,
        PH_ORIGLEN = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        ST_BUSY     = 2'd0,
        ST_DONE     = 2'd1,
        ST_OVERSIZE = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        FLD_NONE = 2'd0,
        FLD_TIME = 2'd1,
        FLD_ORIG = 2'd2
    } t_field;

    // one classified byte, as handed from the front to the back
    typedef struct packed {
        t_status     status;
        logic        header_done;
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [15:0] payload_index;
        t_field      field;
        logic [2:0]  lane;
        logic        orig_end;
        logic [7:0]  data;
        logic [31:0] cap_len;
    } t_entry;

    // phase events seen by the next-state logic
    typedef struct packed {
        logic field_end;
        logic rec_end;
    } t_ph_ev;

    function automatic logic [31:0] put_lane32(input logic [31:0] v,
                                               input logic [1:0]  lane,
                                               input logic [7:0]  b);
        logic [31:0] r;
        r = v;
        r[lane*8 +: 8] = b;
        return r;
    endfunction

    // saturating removal of the link encapsulation
    function automatic logic [31:0] adjust_len(input logic [31:0] v,
                                               input logic        strip);
        logic [31:0] r;
        r = v;
        if (strip) begin
            r = (v > 32'(SKIP_BYTES)) ? v - 32'(SKIP_BYTES) : 32'd0;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

[rtl/prp_front.sv]
// front part: accepts bytes, tracks header phase, captured length and payload count
// depends on prp_pkg
`default_nettype none

module prp_front
    import prp_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_push,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_strip,
    input  wire logic [15:0] i_max_payload,
    output t_entry           o_entry
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_pos, n_pos;
    logic [4:0]  r_skip, n_skip;
    logic [31:0] r_cap, n_cap;
    t_ph_ev      ev;

    // datapath and classification
    always_comb begin
        logic [15:0] pos_nx;
        logic [31:0] cap_w;
        pos_nx = r_pos + 16'd1;
        cap_w  = put_lane32(r_cap, r_pos[1:0], i_data_byte);

        n_pos  = r_pos;
        n_skip = r_skip;
        n_cap  = r_cap;
        ev     = '0;

        o_entry               = '0;
        o_entry.status        = ST_BUSY;
        o_entry.field         = FLD_NONE;
        o_entry.data          = i_data_byte;

        unique case (r_phase)
            PH_TIME: begin
                o_entry.field = FLD_TIME;
                o_entry.lane  = r_pos[2:0];
                ev.field_end  = (pos_nx >= 16'(TIME_BYTES));
                n_pos         = ev.field_end ? 16'd0 : pos_nx;
            end
            PH_CAPLEN: begin
                ev.field_end = (pos_nx >= 16'(LENGTH_BYTES));
                n_pos        = ev.field_end ? 16'd0 : pos_nx;
                n_cap        = ev.field_end ? adjust_len(cap_w, i_strip) : cap_w;
            end
            PH_ORIGLEN: begin
                o_entry.field = FLD_ORIG;
                o_entry.lane  = {1'b0, r_pos[1:0]};
                ev.field_end  = (pos_nx >= 16'(LENGTH_BYTES));
                n_pos         = ev.field_end ? 16'd0 : pos_nx;
                if (ev.field_end) begin
                    o_entry.orig_end    = 1'b1;
                    o_entry.header_done = 1'b1;
                    n_skip              = 5'd0;
                    if (r_cap > {16'd0, i_max_payload}) begin
                        o_entry.status = ST_OVERSIZE;
                        ev.rec_end     = 1'b1;
                    end else if (r_cap == 32'd0) begin
                        o_entry.status = ST_DONE;
                        ev.rec_end     = 1'b1;
                    end
                end
            end
            PH_PAYLOAD: begin
                if (i_strip && (r_skip < 5'(SKIP_BYTES))) begin
                    n_skip = r_skip + 5'd1;
                end else begin
                    o_entry.payload_valid = 1'b1;
                    o_entry.payload_byte  = i_data_byte;
                    o_entry.payload_index = r_pos;
                    n_pos                 = pos_nx;
                    // a wrapped index also ends the record
                    if (({16'd0, pos_nx} >= r_cap) || (pos_nx == 16'd0)) begin
                        o_entry.status = ST_DONE;
                        ev.rec_end     = 1'b1;
                        n_pos          = 16'd0;
                        n_skip         = 5'd0;
                    end
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase

        o_entry.cap_len = n_cap;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_TIME:    if (ev.field_end) n_phase = PH_CAPLEN;
            PH_CAPLEN:  if (ev.field_end) n_phase = PH_ORIGLEN;
            PH_ORIGLEN: if (ev.field_end) n_phase = ev.rec_end ? PH_TIME : PH_PAYLOAD;
            PH_PAYLOAD: if (ev.rec_end)   n_phase = PH_TIME;
            default:    n_phase = PH_TIME;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_TIME;
            r_pos   <= 16'd0;
            r_skip  <= 5'd0;
            r_cap   <= 32'd0;
        end else if (i_push) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_skip  <= n_skip;
            r_cap   <= n_cap;
        end
    end

endmodule

`default_nettype wire

[rtl/prp_queue.sv]
// short queue between front and back, holding classified beats
// depends on prp_pkg
`default_nettype none

module prp_queue
    import prp_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_entry i_entry,
    output logic        o_full,
    input  wire logic   i_pop,
    output logic        o_empty,
    output t_entry      o_entry
);

    localparam int PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_entry             r_mem [Q_DEPTH];
    logic [PTR_W-1:0]   r_wr, r_rd;
    logic [CNT_W-1:0]   r_cnt;

    assign o_full  = (r_cnt == CNT_W'(Q_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_entry = r_mem[r_rd];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wr <= ptr_inc(r_wr);
            if (i_pop)  r_rd <= ptr_inc(r_rd);
            if (i_push && !i_pop)      r_cnt <= r_cnt + CNT_W'(1);
            else if (i_pop && !i_push) r_cnt <= r_cnt - CNT_W'(1);
        end
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(Q_DEPTH))
        else $error("queue count out of range");
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("pop from empty queue");
    a_ptr_track: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_empty || o_full) |-> (r_wr == r_rd))
        else $error("queue pointers disagree with count");
`endif

endmodule

`default_nettype wire

[rtl/prp_back.sv]
// back part: assembles timestamp and original length, holds the result register
// depends on prp_pkg
`default_nettype none

module prp_back
    import prp_pkg::*;
(
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_empty,
    input  wire t_entry       i_entry,
    output logic              o_pop,
    input  wire logic         i_strip,
    output logic              o_out_valid,
    input  wire logic         i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_header_done,
    output logic              o_payload_valid,
    output logic [7:0]        o_payload_byte,
    output logic [15:0]       o_payload_index,
    output logic [31:0]       o_captured_length,
    output logic [31:0]       o_original_length,
    output logic [63:0]       o_timestamp
);

    logic        r_valid;
    t_entry      r_out;
    logic [63:0] r_time, n_time;
    logic [31:0] r_orig, n_orig;

    // next beat may load once the result register is free or being taken
    assign o_pop = !i_empty && (!r_valid || i_out_ready);

    always_comb begin
        logic [31:0] orig_w;
        n_time = r_time;
        orig_w = put_lane32(r_orig, i_entry.lane[1:0], i_entry.data);
        n_orig = r_orig;
        if (i_entry.field == FLD_TIME) begin
            n_time[i_entry.lane*8 +: 8] = i_entry.data;
        end
        if (i_entry.field == FLD_ORIG) begin
            n_orig = i_entry.orig_end ? adjust_len(orig_w, i_strip) : orig_w;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_time  <= 64'd0;
            r_orig  <= 32'd0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_time  <= n_time;
                r_orig  <= n_orig;
            end else if (i_out_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= i_entry;
        end
    end

    assign o_out_valid       = r_valid;
    assign o_status          = r_out.status;
    assign o_header_done     = r_out.header_done;
    assign o_payload_valid   = r_out.payload_valid;
    assign o_payload_byte    = r_out.payload_byte;
    assign o_payload_index   = r_out.payload_index;
    assign o_captured_length = r_out.cap_len;
    assign o_original_length = r_orig;
    assign o_timestamp       = r_time;

endmodule

`default_nettype wire

[rtl/pcap_record_byte_parser.sv]
// capture record byte parser: one input byte gives one result beat
// a byte accepted is registered in the queue, then in the result register, before it shows
// one byte per cycle unless stalled, bounded by front state update and result register
// o_in_ready drops only when the two-entry queue is full behind a stalled output
// reset (i_rst_n low, synchronous) clears phase, counters, header registers; config to defaults
`default_nettype none

module pcap_record_byte_parser
    import prp_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [7:0]           i_data_byte,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic [1:0]                o_status,
    output logic                      o_header_done,
    output logic                      o_payload_valid,
    output logic [7:0]                o_payload_byte,
    output logic [15:0]               o_payload_index,
    output logic [31:0]               o_captured_length,
    output logic [31:0]               o_original_length,
    output logic [63:0]               o_timestamp
);

    logic        r_strip;
    logic [15:0] r_max_payload;
    logic        q_full, q_empty, push, pop;
    t_entry      front_entry, back_entry;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strip       <= 1'b0;
            r_max_payload <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            // unknown indices are ignored
            if (i_cfg_index == CFG_STRIP)   r_strip       <= i_cfg_data[0];
            if (i_cfg_index == CFG_MAX_PAY) r_max_payload <= i_cfg_data;
        end
    end

    assign o_in_ready = !q_full;
    assign push       = i_in_valid && !q_full;

    prp_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_data_byte   (i_data_byte),
        .i_strip       (r_strip),
        .i_max_payload (r_max_payload),
        .o_entry       (front_entry)
    );

    prp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_empty (q_empty),
        .o_entry (back_entry)
    );

    prp_back u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_empty           (q_empty),
        .i_entry           (back_entry),
        .o_pop             (pop),
        .i_strip           (r_strip),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_status          (o_status),
        .o_header_done     (o_header_done),
        .o_payload_valid   (o_payload_valid),
        .o_payload_byte    (o_payload_byte),
        .o_payload_index   (o_payload_index),
        .o_captured_length (o_captured_length),
        .o_original_length (o_original_length),
        .o_timestamp       (o_timestamp)
    );

endmodule

`default_nettype wire

[sim/tb_top.sv]
// testbench for the capture record byte parser: random record streams with a
// byte-level prediction of every result beat; depends on prp_pkg and the rtl
module tb_top;
    import prp_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int HOLD_CYCLES = 80;

    typedef struct packed {
        t_status     status;
        logic        hdr_done;
        logic        pay_valid;
        logic [7:0]  pay_byte;
        logic [15:0] pay_index;
        logic [31:0] cap_len;
        logic [31:0] orig_len;
        logic [63:0] stamp;
    } t_rec_beat;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic [7:0]           in_byte = '0;
    logic                 cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic                 out_ready = 1'b0;

    logic        in_ready;
    logic        cfg_ready;
    logic        out_valid;
    logic [1:0]  status;
    logic        header_done;
    logic        payload_valid;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic [31:0] captured_length;
    logic [31:0] original_length;
    logic [63:0] timestamp;

    // predicted parser state and its register copies
    logic        cfg_strip = 1'b0;
    logic [15:0] cfg_max = 16'hFFFF;
    t_phase      rec_phase = PH_TIME;
    logic [15:0] byte_pos = '0;
    logic [4:0]  skip_cnt = '0;
    logic [63:0] ts_reg = '0;
    logic [31:0] cap_reg = '0;
    logic [31:0] orig_reg = '0;

    logic [7:0] byte_stream_q[$];
    t_rec_beat  expected_beats_q[$];

    int queued_bytes = 0;
    int bytes_sent = 0;
    int beats_seen = 0;
    int hold_left = 0;
    int quiet_cycles = 0;
    int err_count = 0;

    pcap_record_byte_parser uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_data_byte       (in_byte),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_status          (status),
        .o_header_done     (header_done),
        .o_payload_valid   (payload_valid),
        .o_payload_byte    (payload_byte),
        .o_payload_index   (payload_index),
        .o_captured_length (captured_length),
        .o_original_length (original_length),
        .o_timestamp       (timestamp)
    );

    always #2 i_clk = ~i_clk;

    function automatic logic [31:0] less_link(input logic [31:0] v);
        if (!cfg_strip) begin
            return v;
        end
        return (v > SKIP_BYTES) ? v - SKIP_BYTES : 32'd0;
    endfunction

    function automatic t_rec_beat parse_byte(input logic [7:0] b);
        t_rec_beat r;
        r = '0;
        r.status = ST_BUSY;
        case (rec_phase)
            PH_TIME: begin
                ts_reg[byte_pos[2:0]*8 +: 8] = b;
                byte_pos = byte_pos + 16'd1;
                if (byte_pos >= TIME_BYTES) begin
                    byte_pos = '0;
                    rec_phase = PH_CAPLEN;
                end
            end
            PH_CAPLEN: begin
                cap_reg[byte_pos[1:0]*8 +: 8] = b;
                byte_pos = byte_pos + 16'd1;
                if (byte_pos >= LENGTH_BYTES) begin
                    cap_reg = less_link(cap_reg);
                    byte_pos = '0;
                    rec_phase = PH_ORIGLEN;
                end
            end
            PH_ORIGLEN: begin
                orig_reg[byte_pos[1:0]*8 +: 8] = b;
                byte_pos = byte_pos + 16'd1;
                if (byte_pos >= LENGTH_BYTES) begin
                    orig_reg = less_link(orig_reg);
                    byte_pos = '0;
                    skip_cnt = '0;
                    r.hdr_done = 1'b1;
                    if (cap_reg > {16'd0, cfg_max}) begin
                        r.status = ST_OVERSIZE;
                        rec_phase = PH_TIME;
                    end else if (cap_reg == 32'd0) begin
                        r.status = ST_DONE;
                        rec_phase = PH_TIME;
                    end else begin
                        rec_phase = PH_PAYLOAD;
                    end
                end
            end
            default: begin
                if (cfg_strip && skip_cnt < SKIP_BYTES) begin
                    skip_cnt = skip_cnt + 5'd1;
                end else begin
                    r.pay_valid = 1'b1;
                    r.pay_byte = b;
                    r.pay_index = byte_pos;
                    byte_pos = byte_pos + 16'd1;
                    if (byte_pos >= cap_reg || byte_pos == 16'd0) begin
                        r.status = ST_DONE;
                        byte_pos = '0;
                        skip_cnt = '0;
                        rec_phase = PH_TIME;
                    end
                end
            end
        endcase
        r.cap_len = cap_reg;
        r.orig_len = orig_reg;
        r.stamp = ts_reg;
        return r;
    endfunction

    task automatic put_byte(input logic [7:0] b);
        byte_stream_q.push_back(b);
        queued_bytes++;
    endtask

    // header then as many payload bytes as the parser will take, unless cut short
    task automatic push_record(input logic [63:0] ts, input logic [31:0] cap_raw,
                               input logic [31:0] orig_raw, input int cut);
        logic [31:0] adj;
        int n_pay;
        for (int i = 0; i < TIME_BYTES; i++) begin
            put_byte(ts[i*8 +: 8]);
        end
        for (int i = 0; i < LENGTH_BYTES; i++) begin
            put_byte(cap_raw[i*8 +: 8]);
        end
        for (int i = 0; i < LENGTH_BYTES; i++) begin
            put_byte(orig_raw[i*8 +: 8]);
        end
        adj = less_link(cap_raw);
        n_pay = (adj == 0 || adj > cfg_max) ? 0 : int'(adj) + (cfg_strip ? SKIP_BYTES : 0);
        if (cut >= 0 && cut < n_pay) begin
            n_pay = cut;
        end
        repeat (n_pay) put_byte($urandom_range(0, 255));
    endtask

    function automatic logic [31:0] pick_cap_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            return $urandom_range(0, 48);
        end
        if (r < 72) begin
            return $urandom_range(14, 18);
        end
        if (r < 84) begin
            return $urandom;
        end
        if (r < 90 && cfg_max > 300) begin
            return $urandom_range(200, 600);
        end
        if (cfg_max <= 300) begin
            // straddle the oversize boundary
            return cfg_max + (cfg_strip ? SKIP_BYTES : 0) + $urandom_range(0, 2) - 1;
        end
        return $urandom_range(0, 48);
    endfunction

    // broken records and stray bytes only where the maximum keeps payloads short
    task automatic queue_records(input int n, input logic broken);
        int start;
        int unsigned r;
        logic [31:0] orig;
        start = queued_bytes;
        while (queued_bytes - start < n) begin
            r = broken ? $urandom_range(0, 99) : 0;
            orig = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 20) : $urandom;
            if (r < 80) begin
                push_record({$urandom, $urandom}, pick_cap_len(), orig, -1);
            end else if (r < 90) begin
                push_record({$urandom, $urandom}, pick_cap_len(), orig,
                            $urandom_range(0, 24));
            end else begin
                repeat ($urandom_range(1, 6)) put_byte($urandom_range(0, 255));
            end
        end
    endtask

    // sampled away from the rising edge so the driver's updates have settled
    task automatic wait_idle();
        do @(negedge i_clk);
        while (byte_stream_q.size() != 0 || in_valid || expected_beats_q.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // drain, then feed zeros until the parser sits at the start of a record
    task automatic settle();
        wait_idle();
        while (!(rec_phase == PH_TIME && byte_pos == 16'd0)) begin
            put_byte(8'h00);
            wait_idle();
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DAT_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk);
        while (!cfg_ready);
        if (idx == CFG_STRIP) begin
            cfg_strip = val[0];
        end else if (idx == CFG_MAX_PAY) begin
            cfg_max = val;
        end
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_field(input string fname, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, fname, want, got);
            err_count++;
        end
    endtask

    // byte driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                expected_beats_q.push_back(parse_byte(in_byte));
                bytes_sent++;
            end
            if (!in_valid || in_ready) begin
                if (byte_stream_q.size() != 0 &&
                    ((bytes_sent >= 500 && bytes_sent < 800) ||
                     $urandom_range(0, 99) >= 25)) begin
                    in_valid <= 1'b1;
                    in_byte <= byte_stream_q.pop_front();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge i_clk) begin
        t_rec_beat want;
        if (!i_rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (expected_beats_q.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %h",
                             $time, status);
                    err_count++;
                end else begin
                    want = expected_beats_q.pop_front();
                    check_field("status", want.status, status);
                    check_field("header_done", want.hdr_done, header_done);
                    check_field("payload_valid", want.pay_valid, payload_valid);
                    check_field("payload_byte", want.pay_byte, payload_byte);
                    check_field("payload_index", want.pay_index, payload_index);
                    check_field("captured_length", want.cap_len, captured_length);
                    check_field("original_length", want.orig_len, original_length);
                    check_field("timestamp", want.stamp, timestamp);
                end
                beats_seen++;
                // long back-pressure so the parser fills up and stalls its input
                if (beats_seen == 150 || beats_seen == 1000) begin
                    hold_left = HOLD_CYCLES;
                end
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ready <= 1'b0;
            end else begin
                out_ready <= (beats_seen >= 500 && beats_seen < 800) ||
                             ($urandom_range(0, 99) >= 25);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles == STALL_LIMIT) begin
                $display("[pcap_record_byte_parser] ERROR");
                $finish;
            end
        end
    end

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: empty record, single byte record, oversize
        push_record('1, 32'd0, '1, -1);
        push_record('0, 32'd1, 32'd0, -1);
        push_record({$urandom, $urandom}, 32'h0001_0000, $urandom, -1);
        queue_records(200, 1'b0);
        settle();

        write_reg(CFG_STRIP, 16'hFFFF);
        write_reg(CFG_MAX_PAY, 16'd40);
        // saturating adjust, one kept byte after the skip, and the size boundary
        push_record({$urandom, $urandom}, 32'd16, 32'd3, -1);
        push_record({$urandom, $urandom}, 32'd17, 32'd17, -1);
        push_record({$urandom, $urandom}, 32'd56, $urandom, -1);
        push_record({$urandom, $urandom}, 32'd57, $urandom, -1);
        queue_records(300, 1'b1);
        settle();

        write_reg(CFG_IDX_W'($urandom_range(2, 255)), CFG_DAT_W'($urandom));
        write_reg(CFG_STRIP, 16'hFFFE);
        write_reg(CFG_MAX_PAY, 16'd0);
        queue_records(150, 1'b1);
        settle();

        write_reg(CFG_STRIP, 16'd1);
        write_reg(CFG_MAX_PAY, 16'hFFFF);
        queue_records(300, 1'b0);
        settle();

        write_reg(CFG_STRIP, 16'd0);
        write_reg(CFG_MAX_PAY, CFG_DAT_W'($urandom_range(1, 300)));
        queue_records(250, 1'b1);
        settle();

        write_reg(CFG_STRIP, 16'd1);
        write_reg(CFG_MAX_PAY, 16'd1);
        queue_records(120, 1'b1);
        settle();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("[pcap_record_byte_parser] OK");
        end else begin
            $display("[pcap_record_byte_parser] ERROR");
        end
        $finish;
    end

endmodule
